@@ design/ots_pkg.sv @@
package ots_pkg;

	localparam int CNT_W = 20;
	localparam int THR_W = 8;
	localparam int STAT_W = 2;
	localparam int NUM_BINS_DEF = 256;
	localparam int NUM_BINS_MAX = 4096;
	localparam int MUL_W = 32;

	localparam int MAX_IDX_W = $clog2(NUM_BINS_MAX);
	localparam int MAX_SQ_W = 2 * (2 * (CNT_W + MAX_IDX_W) + MAX_IDX_W);
	localparam int MAX_LIMBS = (MAX_SQ_W + MUL_W - 1) / MUL_W;
	localparam int LIMB_CNT_W = $clog2(MAX_LIMBS + 1);

	localparam logic [STAT_W-1:0] STAT_FOUND = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_TRUNC = 2'd2;

	typedef struct packed {
		logic                  go;
		logic [LIMB_CNT_W-1:0] na;
		logic [LIMB_CNT_W-1:0] nb;
	} mul_ctl_t;

endpackage

@@ design/ots_ram.sv @@
module ots_ram #(
	parameter int WIDTH = ots_pkg::CNT_W,
	parameter int DEPTH = ots_pkg::NUM_BINS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/ots_mul.sv @@
module ots_mul #(
	parameter int OPA_W = ots_pkg::MUL_W,
	parameter int OPB_W = ots_pkg::MUL_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ots_pkg::mul_ctl_t      ctl,
	input  logic [OPA_W-1:0]       a,
	input  logic [OPB_W-1:0]       b,
	output logic                   done,
	output logic [OPA_W+OPB_W-1:0] prod
);

	localparam int ACC_W = OPA_W + OPB_W;
	localparam int LW    = ots_pkg::MUL_W;
	localparam int LCW   = ots_pkg::LIMB_CNT_W;
	localparam int POS_W = LCW + 1;

	logic [OPA_W-1:0] a_q;
	logic [OPA_W-1:0] a_sh_q;
	logic [OPB_W-1:0] b_sh_q;
	logic [LCW-1:0]   na_q;
	logic [LCW-1:0]   nb_q;
	logic [LCW-1:0]   i_q;
	logic [LCW-1:0]   j_q;
	logic             busy_q;
	logic [2*LW-1:0]  pp_s1;
	logic [POS_W-1:0] pos_s1;
	logic             vld_s1;
	logic             last_s1;
	logic [ACC_W-1:0] acc_q;
	logic             done_q;
	logic             i_last;
	logic             j_last;

	assign i_last = (i_q == na_q - LCW'(1));
	assign j_last = (j_q == nb_q - LCW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q  <= vld_s1 && last_s1;
			vld_s1  <= busy_q;
			last_s1 <= busy_q && i_last && j_last;
			if (ctl.go) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
			end else if (busy_q) begin
				if (i_last) begin
					i_q <= '0;
					j_q <= j_q + LCW'(1);
					if (j_last) begin
						busy_q <= 1'b0;
					end
				end else begin
					i_q <= i_q + LCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1  <= (2*LW)'(a_sh_q[LW-1:0]) * (2*LW)'(b_sh_q[LW-1:0]);
		pos_s1 <= POS_W'(i_q) + POS_W'(j_q);
		if (ctl.go) begin
			a_q    <= a;
			a_sh_q <= a;
			b_sh_q <= b;
			na_q   <= ctl.na;
			nb_q   <= ctl.nb;
			acc_q  <= '0;
		end else begin
			if (busy_q) begin
				if (i_last) begin
					a_sh_q <= a_q;
					b_sh_q <= b_sh_q >> LW;
				end else begin
					a_sh_q <= a_sh_q >> LW;
				end
			end
			if (vld_s1) begin
				acc_q <= acc_q + (ACC_W'(pp_s1) << (LW * pos_s1));
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ design/otsu_threshold_select.sv @@
// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------
// in       in_valid / in_stall   bin_count[19:0], last_bin
// out      out_valid / out_stall threshold_bin[7:0], status[1:0]
//
// Bins load one per cycle unless stalled; the last bin starts a walk over stored bins.
// A bin of the walk reads its count, then runs six products on the shared 32x32
// multiplier (three when W = 0 or W = N), each of limbs A x limbs B partial products.
// An empty histogram answers in the cycle after its last bin, with no walk.
// Reset clears the counters and totals; the bin memory is not cleared.
// in_stall stays high during the walk and while out_stall holds a finished result.
module otsu_threshold_select #(
	parameter int NUM_BINS = ots_pkg::NUM_BINS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ots_pkg::CNT_W-1:0]  bin_count,
	input  logic                       last_bin,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ots_pkg::THR_W-1:0]  threshold_bin,
	output logic [ots_pkg::STAT_W-1:0] status
);

	localparam int LW     = ots_pkg::MUL_W;
	localparam int LCW    = ots_pkg::LIMB_CNT_W;
	localparam int IDX_W  = $clog2(NUM_BINS);
	localparam int LOAD_W = $clog2(NUM_BINS + 1);
	localparam int NB_W   = ots_pkg::CNT_W + IDX_W;
	localparam int TB_W   = NB_W + IDX_W;
	localparam int DIFF_W = NB_W + TB_W;
	localparam int DEN_W  = 2 * NB_W;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int ACC_W  = SQ_W + DIFF_W;
	localparam int L_NB   = (NB_W + LW - 1) / LW;
	localparam int L_TB   = (TB_W + LW - 1) / LW;
	localparam int L_DIFF = (DIFF_W + LW - 1) / LW;
	localparam int L_DEN  = (DEN_W + LW - 1) / LW;
	localparam int L_SQ   = (SQ_W + LW - 1) / LW;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_OP   = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [2:0] OP_TW  = 3'd0;
	localparam logic [2:0] OP_MN  = 3'd1;
	localparam logic [2:0] OP_DEN = 3'd2;
	localparam logic [2:0] OP_SQ  = 3'd3;
	localparam logic [2:0] OP_LHS = 3'd4;
	localparam logic [2:0] OP_RHS = 3'd5;

	logic [2:0]                 state_q;
	logic [2:0]                 op_q;
	logic                       issued_q;
	logic [LOAD_W-1:0]          bins_q;
	logic [NB_W-1:0]            tot_n_q;
	logic [TB_W-1:0]            tot_t_q;
	logic                       ovf_q;
	logic [IDX_W-1:0]           k_q;
	logic [IDX_W-1:0]           last_k_q;
	logic [NB_W-1:0]            cum_w_q;
	logic [TB_W-1:0]            cum_m_q;
	logic [DIFF_W-1:0]          tw_q;
	logic [DIFF_W-1:0]          diff_q;
	logic [DEN_W-1:0]           den_q;
	logic [SQ_W-1:0]            sq_q;
	logic [ACC_W-1:0]           lhs_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [SQ_W-1:0]            bsq_q;
	logic [DEN_W-1:0]           bden_q;
	logic                       out_valid_q;
	logic [ots_pkg::THR_W-1:0]  thr_q;
	logic [ots_pkg::STAT_W-1:0] status_q;

	logic                       in_acc;
	logic                       store_ok;
	logic [NB_W-1:0]            load_prod;
	logic [NB_W-1:0]            count_n;
	logic [TB_W-1:0]            mom_n;
	logic                       empty_go;
	logic                       fin_go;
	logic [ots_pkg::CNT_W-1:0]  rd_count;
	logic [NB_W-1:0]            walk_prod;
	logic [NB_W-1:0]            w_n;
	logic [TB_W-1:0]            m_n;
	logic                       zero_w;
	ots_pkg::mul_ctl_t          mul_ctl;
	logic [SQ_W-1:0]            mul_a;
	logic [DIFF_W-1:0]          mul_b;
	logic                       mul_done;
	logic [ACC_W-1:0]           mul_prod;
	logic [DIFF_W-1:0]          prod_d;
	logic [DIFF_W-1:0]          diff_c;
	logic                       win;

	assign in_stall = (state_q != ST_LOAD) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign store_ok = (bins_q < LOAD_W'(NUM_BINS));

	assign load_prod = NB_W'(bins_q[IDX_W-1:0]) * NB_W'(bin_count);
	assign count_n   = tot_n_q + (store_ok ? NB_W'(bin_count) : '0);
	assign mom_n     = tot_t_q + (store_ok ? TB_W'(load_prod) : '0);
	assign empty_go  = in_acc && last_bin && (count_n == '0);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	assign walk_prod = NB_W'(k_q) * NB_W'(rd_count);
	assign w_n       = cum_w_q + NB_W'(rd_count);
	assign m_n       = cum_m_q + TB_W'(walk_prod);
	assign zero_w    = (w_n == '0) || (w_n == tot_n_q);

	assign prod_d = mul_prod[DIFF_W-1:0];
	assign diff_c = (tw_q >= prod_d) ? (tw_q - prod_d) : (prod_d - tw_q);
	assign win    = (lhs_q >= mul_prod);

	ots_ram #(
		.WIDTH (ots_pkg::CNT_W),
		.DEPTH (NUM_BINS),
		.AW    (IDX_W)
	) u_bins (
		.clk   (clk),
		.we    (in_acc && store_ok),
		.waddr (bins_q[IDX_W-1:0]),
		.wdata (bin_count),
		.raddr (k_q),
		.rdata (rd_count)
	);

	always_comb begin
		mul_ctl.go = (state_q == ST_OP) && !issued_q;
		mul_ctl.na = LCW'(1);
		mul_ctl.nb = LCW'(1);
		mul_a      = '0;
		mul_b      = '0;
		unique case (op_q)
			OP_TW: begin
				mul_a      = SQ_W'(tot_t_q);
				mul_b      = DIFF_W'(cum_w_q);
				mul_ctl.na = LCW'(L_TB);
				mul_ctl.nb = LCW'(L_NB);
			end
			OP_MN: begin
				mul_a      = SQ_W'(cum_m_q);
				mul_b      = DIFF_W'(tot_n_q);
				mul_ctl.na = LCW'(L_TB);
				mul_ctl.nb = LCW'(L_NB);
			end
			OP_DEN: begin
				mul_a      = SQ_W'(cum_w_q);
				mul_b      = DIFF_W'(tot_n_q - cum_w_q);
				mul_ctl.na = LCW'(L_NB);
				mul_ctl.nb = LCW'(L_NB);
			end
			OP_SQ: begin
				mul_a      = SQ_W'(diff_q);
				mul_b      = diff_q;
				mul_ctl.na = LCW'(L_DIFF);
				mul_ctl.nb = LCW'(L_DIFF);
			end
			OP_LHS: begin
				mul_a      = sq_q;
				mul_b      = DIFF_W'(bden_q);
				mul_ctl.na = LCW'(L_SQ);
				mul_ctl.nb = LCW'(L_DEN);
			end
			OP_RHS: begin
				mul_a      = bsq_q;
				mul_b      = DIFF_W'(den_q);
				mul_ctl.na = LCW'(L_SQ);
				mul_ctl.nb = LCW'(L_DEN);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ots_mul #(
		.OPA_W (SQ_W),
		.OPB_W (DIFF_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			op_q        <= OP_TW;
			issued_q    <= 1'b0;
			bins_q      <= '0;
			tot_n_q     <= '0;
			tot_t_q     <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (store_ok) begin
							bins_q <= bins_q + LOAD_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						tot_n_q <= count_n;
						tot_t_q <= mom_n;
						if (last_bin) begin
							if (count_n == '0) begin
								out_valid_q <= 1'b1;
								bins_q      <= '0;
								tot_n_q     <= '0;
								tot_t_q     <= '0;
								ovf_q       <= 1'b0;
							end else begin
								state_q <= ST_RD;
								k_q     <= '0;
							end
						end
					end
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q  <= ST_OP;
					issued_q <= 1'b0;
					op_q     <= zero_w ? OP_SQ : OP_TW;
				end
				ST_OP: begin
					if (mul_ctl.go) begin
						issued_q <= 1'b1;
					end
					if (mul_done) begin
						issued_q <= 1'b0;
						unique case (op_q)
							OP_TW:  op_q <= OP_MN;
							OP_MN:  op_q <= OP_DEN;
							OP_DEN: op_q <= OP_SQ;
							OP_SQ:  op_q <= OP_LHS;
							OP_LHS: op_q <= OP_RHS;
							OP_RHS: begin
								if (k_q == last_k_q) begin
									state_q <= ST_FIN;
								end else begin
									k_q     <= k_q + IDX_W'(1);
									state_q <= ST_RD;
								end
							end
							default: op_q <= OP_TW;
						endcase
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_LOAD;
						bins_q      <= '0;
						tot_n_q     <= '0;
						tot_t_q     <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_bin) begin
			last_k_q   <= store_ok ? bins_q[IDX_W-1:0] : IDX_W'(bins_q - LOAD_W'(1));
			cum_w_q    <= '0;
			cum_m_q    <= '0;
			best_idx_q <= '0;
			bsq_q      <= '0;
			bden_q     <= DEN_W'(1);
		end
		if (state_q == ST_ACC) begin
			cum_w_q <= w_n;
			cum_m_q <= m_n;
			if (zero_w) begin
				diff_q <= '0;
				den_q  <= DEN_W'(1);
			end
		end
		if ((state_q == ST_OP) && mul_done) begin
			unique case (op_q)
				OP_TW:  tw_q   <= prod_d;
				OP_MN:  diff_q <= diff_c;
				OP_DEN: den_q  <= mul_prod[DEN_W-1:0];
				OP_SQ:  sq_q   <= mul_prod[SQ_W-1:0];
				OP_LHS: lhs_q  <= mul_prod;
				OP_RHS: begin
					if (win) begin
						best_idx_q <= k_q;
						bsq_q      <= sq_q;
						bden_q     <= den_q;
					end
				end
				default: tw_q <= tw_q;
			endcase
		end
		if (empty_go) begin
			thr_q    <= '0;
			status_q <= ots_pkg::STAT_EMPTY;
		end else if (fin_go) begin
			thr_q    <= ots_pkg::THR_W'(best_idx_q);
			status_q <= ovf_q ? ots_pkg::STAT_TRUNC : ots_pkg::STAT_FOUND;
		end
	end

	assign out_valid     = out_valid_q;
	assign threshold_bin = thr_q;
	assign status        = status_q;

	a_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_OP)
		else $error("multiplier finished outside the product step");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LOAD |-> k_q <= last_k_q)
		else $error("walk index passed the last stored bin");

	a_cum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OP |-> cum_w_q <= tot_n_q)
		else $error("cumulative count exceeds total count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ots_pkg::STAT_EMPTY) |-> threshold_bin == '0)
		else $error("empty histogram reported a nonzero bin");

endmodule
